// ===== design/vec3_alu_unit_macros.svh =====
// ----------------------------------------------------------------------------
// vec3_alu_unit_macros: assertion macros
// Shorthands for the concurrent checks of the vector ALU. Each macro expects
// clk and arst_n in scope where it is used.
// ----------------------------------------------------------------------------
`ifndef VEC3_ALU_UNIT_MACROS_SVH
`define VEC3_ALU_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define V3ALU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define V3ALU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/v3alu_pkg.sv =====
// ----------------------------------------------------------------------------
// v3alu_pkg: shared types and constants of the vector ALU
// Operation codes, command and result payloads, and the fixed-point format.
// ----------------------------------------------------------------------------
package v3alu_pkg;

	// Width of every vector component and scalar on the ports.
	localparam int DATA_BITS = 32;
	// Saturation width of a result word; results carry its low DATA_BITS bits.
	localparam int WORD_BITS = 32;
	// Fraction bits of the fixed-point format.
	localparam int FRAC_BITS = 16;

	typedef enum logic [2:0] {
		FN_MAG     = 3'd0,
		FN_DOT     = 3'd1,
		FN_SUM     = 3'd2,
		FN_SUB     = 3'd3,
		FN_SCALE   = 3'd4,
		FN_CROSS   = 3'd5,
		FN_KM_TO_M = 3'd6,
		FN_M_TO_KM = 3'd7
	} func_t;

	typedef struct packed {
		func_t                       func;
		logic signed [DATA_BITS-1:0] a_x;
		logic signed [DATA_BITS-1:0] a_y;
		logic signed [DATA_BITS-1:0] a_z;
		logic                        a_unit;
		logic signed [DATA_BITS-1:0] b_x;
		logic signed [DATA_BITS-1:0] b_y;
		logic signed [DATA_BITS-1:0] b_z;
		logic                        b_unit;
		logic signed [DATA_BITS-1:0] scale;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] res_x;
		logic signed [DATA_BITS-1:0] res_y;
		logic signed [DATA_BITS-1:0] res_z;
		logic signed [DATA_BITS-1:0] res_scalar;
		logic                        res_unit;
		logic                        unit_error;
		logic                        overflow;
	} res_t;

endpackage

// ===== design/v3alu_stream_if.sv =====
// ----------------------------------------------------------------------------
// v3alu_stream_if: valid/ready stream channel
// Carries one payload per transfer; a transfer happens at a rising edge with
// valid and ready both high.
// ----------------------------------------------------------------------------
interface v3alu_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/vec3_alu_unit.sv =====
// ----------------------------------------------------------------------------
// vec3_alu_unit: pipelined three-component fixed-point vector ALU
// Magnitude, dot, sum, difference, scale, cross and unit conversions on
// signed Q16.16 vectors, one command per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// The unit takes one command per clock on cmd and returns exactly one result
// per command on res, in order. Every command, whatever its operation, walks
// the same 19-stage pipeline: stage 1 selects multiplier operands and forms
// sums and differences, stage 2 runs six shared signed multipliers, stage 3
// adds, shifts and negates the products, and stages 4 to 19 run the square
// root for the magnitude two result bits per stage (32 bits over 16 stages),
// while the other results ride along already saturated. The square root
// chain makes up most of the pipeline's depth; throughput is one command
// per cycle while the pipeline does not stall. A two-entry output buffer
// sits behind the pipeline: the pipeline keeps moving while one result waits
// on res, and stalls as a whole (cmd.ready low) only once the spare entry is
// also taken. Unit-tag mismatches on dot, sum, difference and cross return
// all zero values with unit_error set; any saturation of a returned value
// sets overflow.
// ----------------------------------------------------------------------------
module vec3_alu_unit (
	input logic clk,
	input logic arst_n,
	v3alu_stream_if.sink cmd,
	v3alu_stream_if.source res
);

	`include "vec3_alu_unit_macros.svh"

	localparam int DW        = v3alu_pkg::DATA_BITS;
	localparam int FB        = v3alu_pkg::FRAC_BITS;
	// Operands: one sign bit above a component so that |-2^31| fits.
	localparam int OPX_BITS  = DW + 1;
	localparam int OPY_BITS  = DW + 2;
	localparam int PROD_BITS = OPX_BITS + OPY_BITS;
	// Room for the three-product sum of the dot product.
	localparam int WIDE_BITS = PROD_BITS + 2;
	localparam int ROOT_BITS = DW;
	localparam int SQ_BITS   = 2 * ROOT_BITS;
	localparam int REM_BITS  = ROOT_BITS + 3;
	localparam int STEPS_PER_STAGE = 2;
	localparam int RT_STAGES = ROOT_BITS / STEPS_PER_STAGE;

	// Truncating division by 1000 as (|a| * ceil(2^42 / 1000)) >> 42, exact for
	// every |a| below 2^32.
	localparam int DIV_SHIFT = DW + 10;
	localparam logic signed [OPY_BITS-1:0] DIV_MUL = 34'sd4398046512;
	localparam logic signed [OPY_BITS-1:0] KM_MUL  = 34'sd1000;

	localparam logic signed [WIDE_BITS-1:0] SAT_ONE = 1;
	localparam logic signed [WIDE_BITS-1:0] SAT_MAX =
		(SAT_ONE <<< (v3alu_pkg::WORD_BITS - 1)) - SAT_ONE;
	localparam logic signed [WIDE_BITS-1:0] SAT_MIN =
		-(SAT_ONE <<< (v3alu_pkg::WORD_BITS - 1));

	typedef struct packed {
		logic          ovf;
		logic [DW-1:0] val;
	} sat_t;

	typedef struct packed {
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
	} rt_step_t;

	typedef struct packed {
		v3alu_pkg::func_t              func;
		logic                          err;
		logic                          unit;
		logic [2:0]                    an;
		logic [5:0][OPX_BITS-1:0]      ox;
		logic [5:0][OPY_BITS-1:0]      oy;
		logic [2:0][OPX_BITS-1:0]      as;
	} s1_t;

	typedef struct packed {
		v3alu_pkg::func_t              func;
		logic                          err;
		logic                          unit;
		logic [2:0]                    an;
		logic [5:0][PROD_BITS-1:0]     p;
		logic [2:0][OPX_BITS-1:0]      as;
	} s2_t;

	typedef struct packed {
		logic                          is_mag;
		logic                          err;
		logic                          unit;
		logic [2:0][WIDE_BITS-1:0]     w;
		logic [WIDE_BITS-1:0]          dsc;
		logic [SQ_BITS-1:0]            sq;
	} s3_t;

	typedef struct packed {
		logic                          is_mag;
		logic                          err;
		logic                          unit;
		logic                          ovf;
		logic [2:0][DW-1:0]            vec;
		logic [DW-1:0]                 scal;
		logic [SQ_BITS-1:0]            sq;
		logic [REM_BITS-1:0]           rem;
		logic [ROOT_BITS-1:0]          root;
	} rt_t;

	// Saturate a wide signed value to the result word.
	function automatic sat_t sat_word(input logic signed [WIDE_BITS-1:0] v);
		sat_t r;
		r.ovf = 1'b0;
		r.val = v[DW-1:0];
		if (v > SAT_MAX) begin
			r.ovf = 1'b1;
			r.val = SAT_MAX[DW-1:0];
		end else if (v < SAT_MIN) begin
			r.ovf = 1'b1;
			r.val = SAT_MIN[DW-1:0];
		end
		return r;
	endfunction

	// One digit of the restoring square root: bring down two radicand bits and
	// try to subtract 4*root + 1.
	function automatic rt_step_t sqrt_step(input logic [REM_BITS-1:0] rem,
		input logic [ROOT_BITS-1:0] root, input logic [1:0] pair);
		rt_step_t r;
		logic [REM_BITS-1:0] cur;
		logic [REM_BITS-1:0] trial;
		cur   = {rem[REM_BITS-3:0], pair};
		trial = {1'b0, root, 2'b01};
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {root[ROOT_BITS-2:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {root[ROOT_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

	// The whole pipeline advances together unless the spare output entry is full.
	logic adv;
	logic sp_valid_q;
	logic o_valid_q;
	v3alu_pkg::res_t o_q;
	v3alu_pkg::res_t sp_q;

	assign adv       = !sp_valid_q;
	assign cmd.ready = adv;

	// ------------------------------------------------------------------
	// Stage 1: operand selection, unit check, sums and differences.
	// ------------------------------------------------------------------
	s1_t  s1_d;
	s1_t  s1_s1;
	logic v_s1;

	always_comb begin
		logic [2:0][OPX_BITS-1:0] av;
		logic [2:0][OPX_BITS-1:0] bv;
		logic [OPY_BITS-1:0]      sv;
		v3alu_pkg::func_t         fn;
		fn    = cmd.data.func;
		av[0] = {cmd.data.a_x[DW-1], cmd.data.a_x};
		av[1] = {cmd.data.a_y[DW-1], cmd.data.a_y};
		av[2] = {cmd.data.a_z[DW-1], cmd.data.a_z};
		bv[0] = {cmd.data.b_x[DW-1], cmd.data.b_x};
		bv[1] = {cmd.data.b_y[DW-1], cmd.data.b_y};
		bv[2] = {cmd.data.b_z[DW-1], cmd.data.b_z};
		sv    = {{2{cmd.data.scale[DW-1]}}, cmd.data.scale};
		s1_d      = '0;
		s1_d.func = fn;
		s1_d.err  = (fn == v3alu_pkg::FN_DOT || fn == v3alu_pkg::FN_SUM ||
			fn == v3alu_pkg::FN_SUB || fn == v3alu_pkg::FN_CROSS) &&
			(cmd.data.a_unit != cmd.data.b_unit);
		for (int i = 0; i < 3; i++) begin
			s1_d.an[i] = av[i][OPX_BITS-1];
			s1_d.as[i] = (fn == v3alu_pkg::FN_SUB) ? av[i] - bv[i] : av[i] + bv[i];
		end
		case (fn)
			v3alu_pkg::FN_MAG: begin
				for (int i = 0; i < 3; i++) begin
					s1_d.ox[i] = av[i];
					s1_d.oy[i] = {av[i][OPX_BITS-1], av[i]};
				end
			end
			v3alu_pkg::FN_DOT: begin
				for (int i = 0; i < 3; i++) begin
					s1_d.ox[i] = av[i];
					s1_d.oy[i] = {bv[i][OPX_BITS-1], bv[i]};
				end
			end
			v3alu_pkg::FN_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					s1_d.ox[i] = av[i];
					s1_d.oy[i] = sv;
				end
			end
			v3alu_pkg::FN_CROSS: begin
				// Minuends in multipliers 0 to 2, subtrahends in 3 to 5.
				s1_d.ox[0] = av[1];
				s1_d.oy[0] = {bv[2][OPX_BITS-1], bv[2]};
				s1_d.ox[1] = av[2];
				s1_d.oy[1] = {bv[0][OPX_BITS-1], bv[0]};
				s1_d.ox[2] = av[0];
				s1_d.oy[2] = {bv[1][OPX_BITS-1], bv[1]};
				s1_d.ox[3] = av[2];
				s1_d.oy[3] = {bv[1][OPX_BITS-1], bv[1]};
				s1_d.ox[4] = av[0];
				s1_d.oy[4] = {bv[2][OPX_BITS-1], bv[2]};
				s1_d.ox[5] = av[1];
				s1_d.oy[5] = {bv[0][OPX_BITS-1], bv[0]};
			end
			v3alu_pkg::FN_KM_TO_M: begin
				for (int i = 0; i < 3; i++) begin
					s1_d.ox[i] = av[i];
					s1_d.oy[i] = KM_MUL;
				end
			end
			v3alu_pkg::FN_M_TO_KM: begin
				for (int i = 0; i < 3; i++) begin
					s1_d.ox[i] = av[i][OPX_BITS-1] ? -av[i] : av[i];
					s1_d.oy[i] = DIV_MUL;
				end
			end
			default: begin
			end
		endcase
		case (fn)
			v3alu_pkg::FN_SUM, v3alu_pkg::FN_SUB, v3alu_pkg::FN_SCALE,
			v3alu_pkg::FN_CROSS: s1_d.unit = cmd.data.a_unit;
			v3alu_pkg::FN_M_TO_KM: s1_d.unit = 1'b1;
			default: s1_d.unit = 1'b0;
		endcase
		if (s1_d.err) begin
			s1_d.unit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_s1 <= s1_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: six signed multipliers.
	// ------------------------------------------------------------------
	s2_t  s2_d;
	s2_t  s2_s2;
	logic v_s2;

	always_comb begin
		s2_d.func = s1_s1.func;
		s2_d.err  = s1_s1.err;
		s2_d.unit = s1_s1.unit;
		s2_d.an   = s1_s1.an;
		s2_d.as   = s1_s1.as;
		for (int j = 0; j < 6; j++) begin
			s2_d.p[j] = $signed(s1_s1.ox[j]) * $signed(s1_s1.oy[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s2_s2 <= s2_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: combine products, or pass sums on, into wide unsaturated results.
	// ------------------------------------------------------------------
	s3_t  s3_d;
	s3_t  s3_s3;
	logic v_s3;

	always_comb begin
		logic signed [2*3-1:0][WIDE_BITS-1:0] pw;
		logic signed [WIDE_BITS-1:0]          sum3;
		logic signed [WIDE_BITS-1:0]          q;
		for (int j = 0; j < 6; j++) begin
			pw[j] = {{(WIDE_BITS-PROD_BITS){s2_s2.p[j][PROD_BITS-1]}}, s2_s2.p[j]};
		end
		sum3 = $signed(pw[0]) + $signed(pw[1]) + $signed(pw[2]);
		s3_d        = '0;
		s3_d.is_mag = (s2_s2.func == v3alu_pkg::FN_MAG);
		s3_d.err    = s2_s2.err;
		s3_d.unit   = s2_s2.unit;
		s3_d.sq     = sum3[SQ_BITS-1:0];
		if (s2_s2.func == v3alu_pkg::FN_DOT) begin
			s3_d.dsc = sum3 >>> FB;
		end
		for (int i = 0; i < 3; i++) begin
			q = $signed(pw[i]) >>> DIV_SHIFT;
			case (s2_s2.func)
				v3alu_pkg::FN_SUM, v3alu_pkg::FN_SUB:
					s3_d.w[i] = {{(WIDE_BITS-OPX_BITS){s2_s2.as[i][OPX_BITS-1]}},
						s2_s2.as[i]};
				v3alu_pkg::FN_SCALE: s3_d.w[i] = $signed(pw[i]) >>> FB;
				v3alu_pkg::FN_CROSS:
					s3_d.w[i] = ($signed(pw[i]) - $signed(pw[i+3])) >>> FB;
				v3alu_pkg::FN_KM_TO_M: s3_d.w[i] = pw[i];
				v3alu_pkg::FN_M_TO_KM: s3_d.w[i] = s2_s2.an[i] ? -q : q;
				default: s3_d.w[i] = '0;
			endcase
		end
		if (s2_s2.err) begin
			s3_d.w   = '0;
			s3_d.dsc = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s3_s3 <= s3_d;
		end
	end

	// ------------------------------------------------------------------
	// Stages 4 to 19: square root, two result bits per stage. The first of
	// them also saturates the vector and dot results that ride along.
	// ------------------------------------------------------------------
	rt_t                  rt_s4 [RT_STAGES];
	logic [RT_STAGES-1:0] rt_v_s4;
	rt_t                  rt_in [RT_STAGES];
	logic [RT_STAGES-1:0] rt_vin;
	rt_t                  rt_nx [RT_STAGES];

	for (genvar k = 0; k < RT_STAGES; k++) begin : g_rt
		if (k == 0) begin : g_head
			always_comb begin
				rt_t  h;
				sat_t sv;
				h        = '0;
				h.is_mag = s3_s3.is_mag;
				h.err    = s3_s3.err;
				h.unit   = s3_s3.unit;
				h.sq     = s3_s3.sq;
				for (int i = 0; i < 3; i++) begin
					sv       = sat_word(s3_s3.w[i]);
					h.vec[i] = sv.val;
					h.ovf    = h.ovf | sv.ovf;
				end
				sv     = sat_word(s3_s3.dsc);
				h.scal = sv.val;
				h.ovf  = h.ovf | sv.ovf;
				rt_in[k] = h;
			end
			assign rt_vin[k] = v_s3;
		end else begin : g_body
			assign rt_in[k]  = rt_s4[k-1];
			assign rt_vin[k] = rt_v_s4[k-1];
		end

		always_comb begin
			rt_t      t;
			rt_step_t st;
			t = rt_in[k];
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				st = sqrt_step(t.rem, t.root,
					t.sq[SQ_BITS-1-2*(STEPS_PER_STAGE*k+j) -: 2]);
				t.rem  = st.rem;
				t.root = st.root;
			end
			rt_nx[k] = t;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s4[k] <= 1'b0;
			end else if (adv) begin
				rt_v_s4[k] <= rt_vin[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_s4[k] <= rt_nx[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Result assembly and the two-entry output buffer.
	// ------------------------------------------------------------------
	v3alu_pkg::res_t fin;
	logic            push;
	logic            pop;
	logic            load_o;
	logic            load_sp;

	always_comb begin
		rt_t  last;
		sat_t ms;
		last = rt_s4[RT_STAGES-1];
		ms   = sat_word({{(WIDE_BITS-ROOT_BITS){1'b0}}, last.root});
		fin.res_x      = last.vec[0];
		fin.res_y      = last.vec[1];
		fin.res_z      = last.vec[2];
		fin.res_scalar = last.is_mag ? ms.val : last.scal;
		fin.res_unit   = last.unit;
		fin.unit_error = last.err;
		fin.overflow   = last.ovf | (last.is_mag & ms.ovf);
	end

	// The spare entry only fills while the output entry holds a result that is
	// not taken, and the pipeline stops as soon as it is full.
	assign pop     = o_valid_q & res.ready;
	assign push    = adv & rt_v_s4[RT_STAGES-1];
	assign load_o  = push & (!o_valid_q | pop);
	assign load_sp = push & o_valid_q & !pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q  <= 1'b0;
			sp_valid_q <= 1'b0;
		end else if (sp_valid_q) begin
			sp_valid_q <= !pop;
		end else begin
			sp_valid_q <= load_sp;
			if (load_o) begin
				o_valid_q <= 1'b1;
			end else if (pop) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sp_valid_q && pop) begin
			o_q <= sp_q;
		end else if (load_o) begin
			o_q <= fin;
		end
		if (load_sp) begin
			sp_q <= fin;
		end
	end

	assign res.valid = o_valid_q;
	assign res.data  = o_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`V3ALU_ASSERT_IMPL(a_spare_behind_out, sp_valid_q, o_valid_q,
		"spare output entry holds a result while the output entry is empty")
	`V3ALU_ASSERT_NEXT(a_last_stage_held, rt_v_s4[RT_STAGES-1] && !adv,
		rt_v_s4[RT_STAGES-1], "stalled result in the last stage was dropped")
	`V3ALU_ASSERT_IMPL(a_unit_error_clean, o_valid_q && o_q.unit_error,
		!o_q.overflow && !o_q.res_unit && o_q.res_scalar == '0 && o_q.res_x == '0,
		"unit mismatch result carries values or flags")

endmodule
